>>> hdl/jdcm_pkg.sv
package jdcm_pkg;

  typedef enum logic [2:0] {
    OP_ENQ      = 3'd0,
    OP_CLAIM    = 3'd1,
    OP_COMPLETE = 3'd2,
    OP_RET_ONE  = 3'd3,
    OP_RET_ALL  = 3'd4,
    OP_QUERY    = 3'd5,
    OP_RSV6     = 3'd6,
    OP_RSV7     = 3'd7
  } op_t;

  localparam logic [2:0] ST_NEVER     = 3'd0;
  localparam logic [2:0] ST_QUEUED    = 3'd1;
  localparam logic [2:0] ST_RUNNING   = 3'd2;
  localparam logic [2:0] ST_COMPLETED = 3'd3;
  localparam logic [2:0] ST_RETIRED   = 3'd4;

  localparam logic [1:0] RC_OK   = 2'd0;
  localparam logic [1:0] RC_NONE = 2'd1;
  localparam logic [1:0] RC_BAD  = 2'd2;
  localparam logic [1:0] RC_FULL = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_EXEC,
    S_OUT,
    S_RALL
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input item, start status read
    logic scan;     // advance search index
    logic exec;     // apply the operation
    logic rall;     // retire-all step: emit entry at scan index
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic valid_op;
    logic is_scan;   // op needs a search pass
    logic is_rall;
    logic scan_done; // search finished
    logic rall_empty;
    logic rall_last;
  } sts_t;

endpackage

>>> hdl/jdcm_ctrl.sv
module jdcm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  jdcm_pkg::sts_t sts,
  output jdcm_pkg::cmd_t cmd
);
  import jdcm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (!sts.valid_op) state_nxt = S_IDLE;
        else if (sts.is_rall) state_nxt = S_RALL;
        else if (sts.is_scan) state_nxt = S_SCAN;
        else state_nxt = S_EXEC;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      S_RALL: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.rall = 1'b1;
          if (sts.rall_empty || sts.rall_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

>>> hdl/jdcm_dp.sv
module jdcm_dp #(
  parameter int MAX_JOBS     = 256,
  parameter int QUEUE_DEPTH  = 16,
  parameter int CHANNEL_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           in_op,
  input  logic [7:0]           in_job_id,
  input  logic [31:0]          in_channels,
  input  jdcm_pkg::cmd_t       cmd,
  output jdcm_pkg::sts_t       sts,
  output logic [7:0]           out_result_job_id,
  output logic [2:0]           out_job_state,
  output logic [1:0]           out_result_code,
  output logic                 out_last,
  output logic [31:0]          out_completed_total
);
  import jdcm_pkg::*;

  localparam int JW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam int MW = (CHANNEL_BITS < 32) ? CHANNEL_BITS : 32;
  localparam int AW = (JW < 8) ? JW : 8;

  logic [2:0] status_mem [MAX_JOBS];
  logic [JW-1:0] q_ids [QUEUE_DEPTH];
  logic [MW-1:0] q_msk [QUEUE_DEPTH];
  logic [JW-1:0] c_ids [QUEUE_DEPTH];

  logic [CW-1:0] next_id_r;
  logic [NW-1:0] qcnt_r, ccnt_r, idx_r;
  logic [31:0]   events_r;
  op_t           op_r;
  logic [7:0]    id_r;
  logic [MW-1:0] ch_r;
  logic          inrange_r;
  logic [2:0]    rd_r;
  logic [2:0]    st;
  logic          found_r;
  logic [QW-1:0] fidx_r;

  logic [7:0] res_id_r;
  logic [2:0] res_st_r;
  logic [1:0] res_rc_r;

  logic [QW-1:0] idx_q;
  logic          scan_end, hit;
  logic [JW-1:0] idw;
  logic          swr;
  logic [JW-1:0] swa;
  logic [2:0]    swd;

  assign idx_q = idx_r[QW-1:0];
  assign idw = JW'(id_r[AW-1:0]);
  // ids are handed out in order, so only ids below next_id_r were written
  assign st = (inrange_r && (CW'(idw) < next_id_r)) ? rd_r : ST_NEVER;

  always_comb begin
    scan_end = 1'b1;
    hit = 1'b0;
    if (op_r == OP_CLAIM) begin
      scan_end = (idx_r >= qcnt_r);
      hit = !scan_end && ((q_msk[idx_q] & ch_r) != '0);
    end else if (op_r == OP_RET_ONE) begin
      scan_end = (idx_r >= ccnt_r);
      hit = !scan_end && (c_ids[idx_q] == idw);
    end
  end

  assign sts.valid_op = (op_r != OP_RSV6) && (op_r != OP_RSV7);
  assign sts.is_scan = (op_r == OP_CLAIM) || (op_r == OP_RET_ONE);
  assign sts.is_rall = (op_r == OP_RET_ALL);
  assign sts.scan_done = scan_end || hit || found_r;
  assign sts.rall_empty = (ccnt_r == '0);
  assign sts.rall_last = (idx_r + NW'(1) >= ccnt_r);

  always_comb begin
    swr = 1'b0;
    swa = idw;
    swd = ST_NEVER;
    if (cmd.exec) begin
      case (op_r)
        OP_ENQ: begin
          swa = next_id_r[JW-1:0];
          swd = ST_QUEUED;
          swr = (next_id_r < CW'(MAX_JOBS)) && (qcnt_r < NW'(QUEUE_DEPTH));
        end
        OP_CLAIM: begin
          swa = q_ids[fidx_r];
          swd = ST_RUNNING;
          swr = found_r;
        end
        OP_COMPLETE: begin
          swd = ST_COMPLETED;
          swr = (st == ST_RUNNING) && (ccnt_r < NW'(QUEUE_DEPTH));
        end
        OP_RET_ONE: begin
          swd = ST_RETIRED;
          swr = (st == ST_COMPLETED);
        end
        default: swr = 1'b0;
      endcase
    end else if (cmd.rall && ccnt_r != '0) begin
      swa = c_ids[idx_q];
      swd = ST_RETIRED;
      swr = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (swr) status_mem[swa] <= swd;
    rd_r <= status_mem[idw];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r <= '0;
      qcnt_r <= '0;
      ccnt_r <= '0;
      events_r <= '0;
      idx_r <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_r <= op_t'(in_op);
        id_r <= in_job_id;
        inrange_r <= (32'(in_job_id) < 32'(MAX_JOBS));
        ch_r <= in_channels[MW-1:0];
        idx_r <= '0;
        found_r <= 1'b0;
      end
      if (cmd.scan) begin
        if (hit) begin
          found_r <= 1'b1;
          fidx_r <= idx_q;
        end else idx_r <= idx_r + NW'(1);
      end
      if (cmd.exec) begin
        case (op_r)
          OP_ENQ: begin
            if (swr) begin
              res_id_r <= 8'(next_id_r);
              res_st_r <= ST_QUEUED;
              res_rc_r <= RC_OK;
              q_ids[qcnt_r[QW-1:0]] <= next_id_r[JW-1:0];
              q_msk[qcnt_r[QW-1:0]] <= ch_r;
              qcnt_r <= qcnt_r + NW'(1);
              next_id_r <= next_id_r + CW'(1);
            end else begin
              res_id_r <= '0;
              res_st_r <= ST_NEVER;
              res_rc_r <= RC_FULL;
            end
          end
          OP_CLAIM: begin
            if (found_r) begin
              res_id_r <= 8'(q_ids[fidx_r]);
              res_st_r <= ST_RUNNING;
              res_rc_r <= RC_OK;
              for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                if (QW'(i) >= fidx_r) begin
                  q_ids[i] <= q_ids[i+1];
                  q_msk[i] <= q_msk[i+1];
                end
              end
              qcnt_r <= qcnt_r - NW'(1);
            end else begin
              res_id_r <= '0;
              res_st_r <= ST_NEVER;
              res_rc_r <= RC_NONE;
            end
          end
          OP_COMPLETE: begin
            events_r <= events_r + 32'd1;
            res_id_r <= id_r;
            if (st != ST_RUNNING) begin
              res_st_r <= st;
              res_rc_r <= (st == ST_NEVER || st == ST_RETIRED) ? RC_BAD : RC_NONE;
            end else if (!swr) begin
              res_st_r <= st;
              res_rc_r <= RC_FULL;
            end else begin
              res_st_r <= ST_COMPLETED;
              res_rc_r <= RC_OK;
              c_ids[ccnt_r[QW-1:0]] <= idw;
              ccnt_r <= ccnt_r + NW'(1);
            end
          end
          OP_RET_ONE: begin
            res_id_r <= id_r;
            if (!swr) begin
              res_st_r <= st;
              res_rc_r <= (st == ST_NEVER || st == ST_RETIRED) ? RC_BAD : RC_NONE;
            end else begin
              res_st_r <= ST_RETIRED;
              res_rc_r <= RC_OK;
              if (found_r) begin
                for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                  if (QW'(i) >= fidx_r) c_ids[i] <= c_ids[i+1];
                ccnt_r <= ccnt_r - NW'(1);
              end
            end
          end
          default: begin
            res_id_r <= id_r;
            res_st_r <= st;
            res_rc_r <= RC_OK;
          end
        endcase
      end
      if (cmd.rall) begin
        if (ccnt_r == '0 || idx_r + NW'(1) >= ccnt_r) ccnt_r <= '0;
        else idx_r <= idx_r + NW'(1);
      end
    end
  end

  always_comb begin
    if (op_r == OP_RET_ALL) begin
      out_last = sts.rall_empty || sts.rall_last;
      if (sts.rall_empty) begin
        out_result_job_id = '0;
        out_job_state = ST_NEVER;
        out_result_code = RC_NONE;
      end else begin
        out_result_job_id = 8'(c_ids[idx_q]);
        out_job_state = ST_RETIRED;
        out_result_code = RC_OK;
      end
    end else begin
      out_last = 1'b1;
      out_result_job_id = res_id_r;
      out_job_state = res_st_r;
      out_result_code = res_rc_r;
    end
  end
  assign out_completed_total = events_r;
endmodule

>>> hdl/job_dispatch_with_channel_mask.sv
// Job dispatcher with channel-mask affinity.
// Input channel (in_valid/in_ready) carries op, job_id and channels; the
// result channel (out_valid/out_ready) returns one result per item, or one
// per completed job for retire-all, with out_last on the final one.
// One item is handled at a time. Enqueue, complete and query pass through
// a status read state and an execute state before they present their
// result. Claim and retire-one add a search state between the two that
// compares one queue or completed-list entry at a time, in order, until the
// first match or the end of the list.
// Retire-all goes from the status read state to presenting its first result,
// then one result per cycle while the receiver is ready.
// The status table is a memory with one write and one read port; ids at or
// above the next job id read as never seen.
// Reserved ops are dropped with no result; the block goes back to idle
// after the status read state.
// Synchronous reset clears all counts, so every job reads as never seen;
// no clearing pass is needed. A stalled receiver holds the result and the
// block takes no new item until every result of the current one is taken.
module job_dispatch_with_channel_mask #(
  parameter int MAX_JOBS     = 256,
  parameter int QUEUE_DEPTH  = 16,
  parameter int CHANNEL_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_job_id,
  input  logic [31:0] in_channels,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_result_job_id,
  output logic [2:0]  out_job_state,
  output logic [1:0]  out_result_code,
  output logic        out_last,
  output logic [31:0] out_completed_total
);
  import jdcm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  jdcm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts, .cmd
  );

  jdcm_dp #(
    .MAX_JOBS(MAX_JOBS), .QUEUE_DEPTH(QUEUE_DEPTH), .CHANNEL_BITS(CHANNEL_BITS)
  ) u_dp (
    .clk, .rst_n, .in_op, .in_job_id, .in_channels, .cmd, .sts,
    .out_result_job_id, .out_job_state, .out_result_code, .out_last,
    .out_completed_total
  );
endmodule

>>> tb/sv/job_dispatch_with_channel_mask_test.sv
`timescale 1ns / 100ps

module job_dispatch_with_channel_mask_test;
  import jdcm_pkg::*;

  localparam int NJOBS = 256;
  localparam int QDEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM = 390;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0]  job_id;
    logic [2:0]  state;
    logic [1:0]  code;
    logic        last;
    logic [31:0] total;
  } result_t;

  typedef struct {
    op_t         op;
    logic [7:0]  job_id;
    logic [31:0] channels;
    bit          typed;
    result_t     want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_op = '0;
  logic [7:0]  in_job_id = '0;
  logic [31:0] in_channels = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_result_job_id;
  logic [2:0]  out_job_state;
  logic [1:0]  out_result_code;
  logic        out_last;
  logic [31:0] out_completed_total;

  job_dispatch_with_channel_mask dut (.*);

  always #4 clk = ~clk;

  // dispatcher shadow state
  logic [2:0]  job_status [NJOBS];
  int unsigned id_counter;
  logic [7:0]  pend_ids [$];
  logic [31:0] pend_masks [$];
  logic [7:0]  done_ids [$];
  logic [31:0] done_events;

  result_t     results_due [$];
  int          err_count = 0;
  int          cycles = 0;
  bit          hold_req = 1'b0;
  bit          hold_rx = 1'b0;

  function automatic string fmt(result_t r);
    return $sformatf("id=%0d st=%0d rc=%0d last=%0d tot=%0d",
                     r.job_id, r.state, r.code, r.last, r.total);
  endfunction

  task automatic report(input string what, input result_t got, input result_t want);
    $display("mismatch %s: got %s, want %s", what, fmt(got), fmt(want));
    err_count++;
  endtask

  function automatic result_t mk(logic [7:0] id, logic [2:0] st, logic [1:0] rc, logic l);
    result_t r;
    r.job_id = id; r.state = st; r.code = rc; r.last = l; r.total = done_events;
    return r;
  endfunction

  function automatic void due_add(result_t r);
    results_due.insert(results_due.size(), r);
  endfunction

  function automatic logic [1:0] bad_code(logic [2:0] st);
    return (st == ST_NEVER || st == ST_RETIRED) ? RC_BAD : RC_NONE;
  endfunction

  // applies one item to the shadow state and queues what it should produce
  function automatic void dispatch_predict(op_t op, logic [7:0] id, logic [31:0] ch);
    logic [2:0] st;
    bit hit;
    st = job_status[id];
    hit = 1'b0;
    case (op)
      OP_ENQ: begin
        if (id_counter >= NJOBS || pend_ids.size() >= QDEPTH) begin
          due_add(mk(8'd0, ST_NEVER, RC_FULL, 1'b1));
        end else begin
          job_status[id_counter] = ST_QUEUED;
          pend_ids.insert(pend_ids.size(), id_counter[7:0]);
          pend_masks.insert(pend_masks.size(), ch);
          due_add(mk(id_counter[7:0], ST_QUEUED, RC_OK, 1'b1));
          id_counter++;
        end
      end
      OP_CLAIM: begin
        for (int i = 0; i < pend_ids.size(); i++) begin
          if (!hit && (pend_masks[i] & ch) != 0) begin
            hit = 1'b1;
            job_status[pend_ids[i]] = ST_RUNNING;
            due_add(mk(pend_ids[i], ST_RUNNING, RC_OK, 1'b1));
            pend_ids.delete(i);
            pend_masks.delete(i);
          end
        end
        if (!hit) due_add(mk(8'd0, ST_NEVER, RC_NONE, 1'b1));
      end
      OP_COMPLETE: begin
        done_events++;
        if (st != ST_RUNNING) due_add(mk(id, st, bad_code(st), 1'b1));
        else if (done_ids.size() >= QDEPTH) due_add(mk(id, st, RC_FULL, 1'b1));
        else begin
          job_status[id] = ST_COMPLETED;
          done_ids.insert(done_ids.size(), id);
          due_add(mk(id, ST_COMPLETED, RC_OK, 1'b1));
        end
      end
      OP_RET_ONE: begin
        if (st != ST_COMPLETED) due_add(mk(id, st, bad_code(st), 1'b1));
        else begin
          for (int i = 0; i < done_ids.size(); i++)
            if (!hit && done_ids[i] == id) begin
              hit = 1'b1;
              done_ids.delete(i);
            end
          job_status[id] = ST_RETIRED;
          due_add(mk(id, ST_RETIRED, RC_OK, 1'b1));
        end
      end
      OP_RET_ALL: begin
        if (done_ids.size() == 0) due_add(mk(8'd0, ST_NEVER, RC_NONE, 1'b1));
        foreach (done_ids[i]) begin
          job_status[done_ids[i]] = ST_RETIRED;
          due_add(mk(done_ids[i], ST_RETIRED, RC_OK, i == done_ids.size() - 1));
        end
        done_ids.delete();
      end
      OP_QUERY: due_add(mk(id, st, RC_OK, 1'b1));
      default: ;
    endcase
  endfunction

  task automatic send(input op_t op, input logic [7:0] id, input logic [31:0] ch,
                      input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_job_id <= id;
    in_channels <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    dispatch_predict(op, id, ch);
  endtask

  task automatic drain_wait;
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_result_job_id, out_job_state, out_result_code, out_last,
             out_completed_total};
      if (results_due.size() == 0) begin
        report("unexpected transfer", got, got);
      end else begin
        if (got !== results_due[0]) report("field", got, results_due[0]);
        void'(results_due.pop_front());
      end
    end
  end

  initial begin
    int wait_n;
    forever begin
      @(posedge clk);
      if (hold_rx) out_ready <= 1'b0;
      else if (out_ready && out_valid) begin
        wait_n = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) wait_n = 0;
        if (wait_n != 0) begin
          out_ready <= 1'b0;
          repeat (wait_n) @(posedge clk);
        end
        out_ready <= 1'b1;
      end else out_ready <= 1'b1;
    end
  end

  // long receiver stall
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    row_t r;
    op_t  op;
    logic [7:0] id;
    logic [31:0] ch;
    int pick;
    for (int i = 0; i < NJOBS; i++) job_status[i] = ST_NEVER;
    id_counter = 0;
    done_events = 0;

    // directed table; typed rows carry hand-read results
    rows = '{
      '{OP_QUERY,    8'd0,   32'h0,        1'b1, '{8'd0,   ST_NEVER,  RC_OK,   1'b1, 32'd0}},
      '{OP_QUERY,    8'd255, 32'h0,        1'b1, '{8'd255, ST_NEVER,  RC_OK,   1'b1, 32'd0}},
      '{OP_CLAIM,    8'd0,   32'hFFFFFFFF, 1'b1, '{8'd0,   ST_NEVER,  RC_NONE, 1'b1, 32'd0}},
      '{OP_RET_ALL,  8'd0,   32'h0,        1'b1, '{8'd0,   ST_NEVER,  RC_NONE, 1'b1, 32'd0}},
      '{OP_COMPLETE, 8'd7,   32'h0,        1'b1, '{8'd7,   ST_NEVER,  RC_BAD,  1'b1, 32'd1}},
      '{OP_RET_ONE,  8'd9,   32'h0,        1'b1, '{8'd9,   ST_NEVER,  RC_BAD,  1'b1, 32'd1}},
      '{OP_ENQ,      8'd0,   32'h80000000, 1'b1, '{8'd0,   ST_QUEUED, RC_OK,   1'b1, 32'd1}},
      '{OP_ENQ,      8'd0,   32'h00000001, 1'b1, '{8'd1,   ST_QUEUED, RC_OK,   1'b1, 32'd1}},
      '{OP_ENQ,      8'd0,   32'h0,        1'b1, '{8'd2,   ST_QUEUED, RC_OK,   1'b1, 32'd1}},
      '{OP_RSV6,     8'd3,   32'h5,        1'b0, '0},
      '{OP_RSV7,     8'd3,   32'h5,        1'b0, '0},
      '{OP_CLAIM,    8'd0,   32'h00000001, 1'b0, '0},
      '{OP_CLAIM,    8'd0,   32'hFFFFFFFF, 1'b0, '0},
      '{OP_CLAIM,    8'd0,   32'hFFFFFFFF, 1'b0, '0},
      '{OP_COMPLETE, 8'd2,   32'h0,        1'b0, '0},
      '{OP_RET_ONE,  8'd0,   32'h0,        1'b0, '0},
      '{OP_COMPLETE, 8'd1,   32'h0,        1'b0, '0},
      '{OP_COMPLETE, 8'd0,   32'h0,        1'b0, '0},
      '{OP_COMPLETE, 8'd0,   32'h0,        1'b0, '0},
      '{OP_RET_ONE,  8'd1,   32'h0,        1'b0, '0},
      '{OP_RET_ONE,  8'd1,   32'h0,        1'b0, '0},
      '{OP_RET_ALL,  8'd0,   32'h0,        1'b0, '0},
      '{OP_QUERY,    8'd0,   32'h0,        1'b0, '0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      r = rows[i];
      send(r.op, r.job_id, r.channels, 1'b1);
      if (r.typed) begin
        if (results_due.size() == 0 || results_due[$] !== r.want)
          report("table row", results_due.size() ? results_due[$] : '0, r.want);
      end
    end
    drain_wait();

    // stall the receiver while enqueues keep coming and back up the input
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send(OP_ENQ, 8'd0, $urandom, 1'b0);
    drain_wait();

    for (int n = 0; n < N_RANDOM; n++) begin
      pick = $urandom_range(0, 99);
      ch = $urandom;
      if ($urandom_range(0, 3) == 0) ch = 32'h1 << $urandom_range(0, 31);
      id = (id_counter > 0 && $urandom_range(0, 4) != 0)
           ? 8'($urandom_range(0, id_counter - 1)) : 8'($urandom);
      if (done_ids.size() && $urandom_range(0, 1))
        id = done_ids[$urandom_range(0, done_ids.size()-1)];
      if (pick < 25) op = OP_ENQ;
      else if (pick < 45) op = OP_CLAIM;
      else if (pick < 68) op = OP_COMPLETE;
      else if (pick < 80) op = OP_RET_ONE;
      else if (pick < 86) op = OP_RET_ALL;
      else if (pick < 96) op = OP_QUERY;
      else op = ($urandom_range(0, 1)) ? OP_RSV6 : OP_RSV7;
      if (op == OP_COMPLETE && $urandom_range(0, 2) != 0) begin
        for (int j = 0; j < NJOBS; j++)
          if (job_status[j] == ST_RUNNING && $urandom_range(0, 1)) id = j[7:0];
      end
      send(op, id, ch, n % 60 < 45);
      if (n == 200) drain_wait();
    end

    drain_wait();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> job_dispatch_with_channel_mask.f
hdl/jdcm_pkg.sv
hdl/jdcm_ctrl.sv
hdl/jdcm_dp.sv
hdl/job_dispatch_with_channel_mask.sv
tb/sv/job_dispatch_with_channel_mask_test.sv
